[rtl/core/rvu_pkg.sv]
// Shared types and codes for the RV32I to micro-op decoder.
package rvu_pkg;

   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_OPIMM  = 7'h13;
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_FENCE  = 7'h0F;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;
   localparam logic [6:0] FUNCT7_ALT = 7'h20;

   localparam logic [3:0] KIND_BAD    = 4'd0;
   localparam logic [3:0] KIND_LUI    = 4'd1;
   localparam logic [3:0] KIND_AUIPC  = 4'd2;
   localparam logic [3:0] KIND_JAL    = 4'd3;
   localparam logic [3:0] KIND_JALR   = 4'd4;
   localparam logic [3:0] KIND_BRANCH = 4'd5;
   localparam logic [3:0] KIND_LOAD   = 4'd6;
   localparam logic [3:0] KIND_STORE  = 4'd7;
   localparam logic [3:0] KIND_OPIMM  = 4'd8;
   localparam logic [3:0] KIND_OP     = 4'd9;
   localparam logic [3:0] KIND_FENCE  = 4'd10;
   localparam logic [3:0] KIND_SYSTEM = 4'd11;

   localparam logic [2:0] CLS_NOP = 3'd0;
   localparam logic [2:0] CLS_INT = 3'd1;
   localparam logic [2:0] CLS_BR  = 3'd2;
   localparam logic [2:0] CLS_MEM = 3'd3;
   localparam logic [2:0] CLS_CSR = 3'd4;

   localparam logic [5:0] UOP_NOP     = 6'd0;
   localparam logic [5:0] UOP_LUI     = 6'd1;
   localparam logic [5:0] UOP_AUIPC   = 6'd2;
   localparam logic [5:0] UOP_JAL     = 6'd3;
   localparam logic [5:0] UOP_JALR    = 6'd4;
   localparam logic [5:0] UOP_BEQ     = 6'd5;
   localparam logic [5:0] UOP_BNE     = 6'd6;
   localparam logic [5:0] UOP_BLT     = 6'd7;
   localparam logic [5:0] UOP_BGE     = 6'd8;
   localparam logic [5:0] UOP_BLTU    = 6'd9;
   localparam logic [5:0] UOP_BGEU    = 6'd10;
   localparam logic [5:0] UOP_LB      = 6'd11;
   localparam logic [5:0] UOP_LH      = 6'd12;
   localparam logic [5:0] UOP_LW      = 6'd13;
   localparam logic [5:0] UOP_LBU     = 6'd14;
   localparam logic [5:0] UOP_LHU     = 6'd15;
   localparam logic [5:0] UOP_SB      = 6'd16;
   localparam logic [5:0] UOP_SH      = 6'd17;
   localparam logic [5:0] UOP_SW      = 6'd18;
   localparam logic [5:0] UOP_ADDI    = 6'd19;
   localparam logic [5:0] UOP_SLTI    = 6'd20;
   localparam logic [5:0] UOP_SLTIU   = 6'd21;
   localparam logic [5:0] UOP_XORI    = 6'd22;
   localparam logic [5:0] UOP_ORI     = 6'd23;
   localparam logic [5:0] UOP_ANDI    = 6'd24;
   localparam logic [5:0] UOP_SLLI    = 6'd25;
   localparam logic [5:0] UOP_SRLI    = 6'd26;
   localparam logic [5:0] UOP_SRAI    = 6'd27;
   localparam logic [5:0] UOP_ADD     = 6'd28;
   localparam logic [5:0] UOP_SUB     = 6'd29;
   localparam logic [5:0] UOP_SLL     = 6'd30;
   localparam logic [5:0] UOP_SLT     = 6'd31;
   localparam logic [5:0] UOP_SLTU    = 6'd32;
   localparam logic [5:0] UOP_XOR     = 6'd33;
   localparam logic [5:0] UOP_SRL     = 6'd34;
   localparam logic [5:0] UOP_SRA     = 6'd35;
   localparam logic [5:0] UOP_OR      = 6'd36;
   localparam logic [5:0] UOP_AND     = 6'd37;
   localparam logic [5:0] UOP_FENCE   = 6'd38;
   localparam logic [5:0] UOP_FENCE_I = 6'd39;
   localparam logic [5:0] UOP_ECALL   = 6'd40;
   localparam logic [5:0] UOP_EBREAK  = 6'd41;
   localparam logic [5:0] UOP_CSRRW   = 6'd42;
   localparam logic [5:0] UOP_CSRRS   = 6'd43;
   localparam logic [5:0] UOP_CSRRC   = 6'd44;
   localparam logic [5:0] UOP_CSRRWI  = 6'd45;
   localparam logic [5:0] UOP_CSRRSI  = 6'd46;
   localparam logic [5:0] UOP_CSRRCI  = 6'd47;

   localparam int FLG_BRANCH = 0;
   localparam int FLG_CALL   = 1;
   localparam int FLG_RETURN = 2;
   localparam int FLG_LOAD   = 3;
   localparam int FLG_STORE  = 4;
   localparam int FLG_PTAKEN = 5;

   typedef struct packed {
      logic [31:0] instr_word;
      logic [63:0] fetch_pc;
      logic        predicted_taken;
   } req_type;

   typedef struct packed {
      logic [2:0]         uop_class;
      logic [5:0]         sub_op;
      logic [5:0]         flags;
      logic               src1_enable;
      logic [4:0]         src1_reg;
      logic               src2_enable;
      logic [4:0]         src2_reg;
      logic               dest_enable;
      logic [4:0]         dest_reg;
      logic signed [31:0] immediate;
      logic [63:0]        target_pc;
      logic               illegal_instr;
   } rsp_type;

   // predecoded instruction fields
   typedef struct packed {
      logic [3:0]  kind;
      logic [2:0]  funct3;
      logic        funct7_alt;
      logic        funct12_zero;
      logic        funct12_one;
      logic [4:0]  rd;
      logic [4:0]  rs1;
      logic [4:0]  rs2;
      logic [31:0] imm;
      logic [63:0] pc;
      logic        ptaken;
   } pd_type;

   // decoded micro-op, target still to be added
   typedef struct packed {
      logic [2:0]  uop_class;
      logic [5:0]  sub_op;
      logic [5:0]  flags;
      logic        src1_enable;
      logic [4:0]  src1_reg;
      logic        src2_enable;
      logic [4:0]  src2_reg;
      logic        dest_enable;
      logic [4:0]  dest_reg;
      logic [31:0] imm;
      logic        target_en;
      logic [63:0] pc;
      logic        illegal;
   } uop_type;

endpackage

[rtl/core/rvu_predecode.sv]
// Input register, opcode classification and immediate extraction stage.
module rvu_predecode (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  rvu_pkg::req_type in_req,
   output logic            pd_valid,
   output rvu_pkg::pd_type pd
);

   logic             req_valid_ff;
   rvu_pkg::req_type req_ff;
   logic             pd_valid_ff;
   rvu_pkg::pd_type  pd_ff;
   rvu_pkg::pd_type  pd_in;
   logic [31:0]      w;
   logic [31:0]      imm_i, imm_s, imm_b, imm_u, imm_j;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         pd_valid_ff  <= 1'b0;
      end else begin
         req_valid_ff <= in_valid;
         pd_valid_ff  <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= in_req;
      pd_ff  <= pd_in;
   end

   assign w     = req_ff.instr_word;
   assign imm_i = {{20{w[31]}}, w[31:20]};
   assign imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
   assign imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
   assign imm_u = {w[31:12], 12'b0};
   assign imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};

   always_comb begin
      pd_in              = '0;
      pd_in.funct3       = w[14:12];
      pd_in.funct7_alt   = (w[31:25] == rvu_pkg::FUNCT7_ALT);
      pd_in.funct12_zero = (w[31:20] == 12'd0);
      pd_in.funct12_one  = (w[31:20] == 12'd1);
      pd_in.rd           = w[11:7];
      pd_in.rs1          = w[19:15];
      pd_in.rs2          = w[24:20];
      pd_in.pc           = req_ff.fetch_pc;
      pd_in.ptaken       = req_ff.predicted_taken;
      unique case (w[6:0])
         rvu_pkg::OPC_LUI: begin
            pd_in.kind = rvu_pkg::KIND_LUI;
            pd_in.imm  = imm_u;
         end
         rvu_pkg::OPC_AUIPC: begin
            pd_in.kind = rvu_pkg::KIND_AUIPC;
            pd_in.imm  = imm_u;
         end
         rvu_pkg::OPC_JAL: begin
            pd_in.kind = rvu_pkg::KIND_JAL;
            pd_in.imm  = imm_j;
         end
         rvu_pkg::OPC_JALR: begin
            pd_in.kind = rvu_pkg::KIND_JALR;
            pd_in.imm  = imm_i;
         end
         rvu_pkg::OPC_BRANCH: begin
            pd_in.kind = rvu_pkg::KIND_BRANCH;
            pd_in.imm  = imm_b;
         end
         rvu_pkg::OPC_LOAD: begin
            pd_in.kind = rvu_pkg::KIND_LOAD;
            pd_in.imm  = imm_i;
         end
         rvu_pkg::OPC_STORE: begin
            pd_in.kind = rvu_pkg::KIND_STORE;
            pd_in.imm  = imm_s;
         end
         rvu_pkg::OPC_OPIMM: begin
            pd_in.kind = rvu_pkg::KIND_OPIMM;
            pd_in.imm  = imm_i;
         end
         rvu_pkg::OPC_OP:     pd_in.kind = rvu_pkg::KIND_OP;
         rvu_pkg::OPC_FENCE:  pd_in.kind = rvu_pkg::KIND_FENCE;
         rvu_pkg::OPC_SYSTEM: pd_in.kind = rvu_pkg::KIND_SYSTEM;
         default:             pd_in.kind = rvu_pkg::KIND_BAD;
      endcase
   end

   assign pd_valid = pd_valid_ff;
   assign pd       = pd_ff;

endmodule

[rtl/core/rvu_opgen.sv]
// Micro-op generation stage: class, sub-op, flags, register fields, illegal check.
module rvu_opgen (
   input  logic             clock,
   input  logic             reset,
   input  logic             pd_valid,
   input  rvu_pkg::pd_type  pd,
   output logic             uop_valid,
   output rvu_pkg::uop_type uop
);

   logic             uop_valid_ff;
   rvu_pkg::uop_type uop_ff;
   rvu_pkg::uop_type uop_in;
   logic             link_rd;
   logic             link_rs1;

   assign link_rd  = (pd.rd == 5'd1) || (pd.rd == 5'd5);
   assign link_rs1 = (pd.rs1 == 5'd1) || (pd.rs1 == 5'd5);

   always_ff @(posedge clock) begin
      if (reset) begin
         uop_valid_ff <= 1'b0;
      end else begin
         uop_valid_ff <= pd_valid;
      end
   end

   always_ff @(posedge clock) begin
      uop_ff <= uop_in;
   end

   always_comb begin
      uop_in     = '0;
      uop_in.pc  = pd.pc;
      uop_in.imm = pd.imm;
      unique case (pd.kind)
         rvu_pkg::KIND_LUI: begin
            uop_in.uop_class   = rvu_pkg::CLS_INT;
            uop_in.sub_op      = rvu_pkg::UOP_LUI;
            uop_in.dest_enable = 1'b1;
            uop_in.dest_reg    = pd.rd;
         end
         rvu_pkg::KIND_AUIPC: begin
            uop_in.uop_class   = rvu_pkg::CLS_INT;
            uop_in.sub_op      = rvu_pkg::UOP_AUIPC;
            uop_in.dest_enable = 1'b1;
            uop_in.dest_reg    = pd.rd;
            uop_in.src1_enable = 1'b1;
         end
         rvu_pkg::KIND_JAL: begin
            uop_in.uop_class                  = rvu_pkg::CLS_BR;
            uop_in.sub_op                     = rvu_pkg::UOP_JAL;
            uop_in.flags[rvu_pkg::FLG_BRANCH] = 1'b1;
            uop_in.flags[rvu_pkg::FLG_CALL]   = link_rd;
            uop_in.dest_enable                = 1'b1;
            uop_in.dest_reg                   = pd.rd;
            uop_in.target_en                  = 1'b1;
         end
         rvu_pkg::KIND_JALR: begin
            uop_in.uop_class                  = rvu_pkg::CLS_BR;
            uop_in.sub_op                     = rvu_pkg::UOP_JALR;
            uop_in.flags[rvu_pkg::FLG_BRANCH] = 1'b1;
            uop_in.flags[rvu_pkg::FLG_CALL]   = link_rd;
            uop_in.flags[rvu_pkg::FLG_RETURN] = link_rs1 && (pd.rd == 5'd0);
            uop_in.dest_enable                = 1'b1;
            uop_in.dest_reg                   = pd.rd;
            uop_in.src1_enable                = 1'b1;
            uop_in.src1_reg                   = pd.rs1;
         end
         rvu_pkg::KIND_BRANCH: begin
            uop_in.uop_class                  = rvu_pkg::CLS_BR;
            uop_in.flags[rvu_pkg::FLG_BRANCH] = 1'b1;
            uop_in.src1_enable                = 1'b1;
            uop_in.src1_reg                   = pd.rs1;
            uop_in.src2_enable                = 1'b1;
            uop_in.src2_reg                   = pd.rs2;
            uop_in.target_en                  = 1'b1;
            unique case (pd.funct3)
               3'd0:    uop_in.sub_op = rvu_pkg::UOP_BEQ;
               3'd1:    uop_in.sub_op = rvu_pkg::UOP_BNE;
               3'd4:    uop_in.sub_op = rvu_pkg::UOP_BLT;
               3'd5:    uop_in.sub_op = rvu_pkg::UOP_BGE;
               3'd6:    uop_in.sub_op = rvu_pkg::UOP_BLTU;
               3'd7:    uop_in.sub_op = rvu_pkg::UOP_BGEU;
               default: uop_in.illegal = 1'b1;
            endcase
         end
         rvu_pkg::KIND_LOAD: begin
            uop_in.uop_class                = rvu_pkg::CLS_MEM;
            uop_in.flags[rvu_pkg::FLG_LOAD] = 1'b1;
            uop_in.src1_enable              = 1'b1;
            uop_in.src1_reg                 = pd.rs1;
            uop_in.dest_enable              = 1'b1;
            uop_in.dest_reg                 = pd.rd;
            unique case (pd.funct3)
               3'd0:    uop_in.sub_op = rvu_pkg::UOP_LB;
               3'd1:    uop_in.sub_op = rvu_pkg::UOP_LH;
               3'd2:    uop_in.sub_op = rvu_pkg::UOP_LW;
               3'd4:    uop_in.sub_op = rvu_pkg::UOP_LBU;
               3'd5:    uop_in.sub_op = rvu_pkg::UOP_LHU;
               default: uop_in.illegal = 1'b1;
            endcase
         end
         rvu_pkg::KIND_STORE: begin
            uop_in.uop_class                 = rvu_pkg::CLS_MEM;
            uop_in.flags[rvu_pkg::FLG_STORE] = 1'b1;
            uop_in.src1_enable               = 1'b1;
            uop_in.src1_reg                  = pd.rs1;
            uop_in.src2_enable               = 1'b1;
            uop_in.src2_reg                  = pd.rs2;
            unique case (pd.funct3)
               3'd0:    uop_in.sub_op = rvu_pkg::UOP_SB;
               3'd1:    uop_in.sub_op = rvu_pkg::UOP_SH;
               3'd2:    uop_in.sub_op = rvu_pkg::UOP_SW;
               default: uop_in.illegal = 1'b1;
            endcase
         end
         rvu_pkg::KIND_OPIMM: begin
            uop_in.uop_class   = rvu_pkg::CLS_INT;
            uop_in.src1_enable = 1'b1;
            uop_in.src1_reg    = pd.rs1;
            uop_in.dest_enable = 1'b1;
            uop_in.dest_reg    = pd.rd;
            unique case (pd.funct3)
               3'd0: uop_in.sub_op = rvu_pkg::UOP_ADDI;
               3'd1: uop_in.sub_op = rvu_pkg::UOP_SLLI;
               3'd2: uop_in.sub_op = rvu_pkg::UOP_SLTI;
               3'd3: uop_in.sub_op = rvu_pkg::UOP_SLTIU;
               3'd4: uop_in.sub_op = rvu_pkg::UOP_XORI;
               3'd5: uop_in.sub_op = pd.funct7_alt ? rvu_pkg::UOP_SRAI : rvu_pkg::UOP_SRLI;
               3'd6: uop_in.sub_op = rvu_pkg::UOP_ORI;
               default: uop_in.sub_op = rvu_pkg::UOP_ANDI;
            endcase
         end
         rvu_pkg::KIND_OP: begin
            uop_in.uop_class   = rvu_pkg::CLS_INT;
            uop_in.src1_enable = 1'b1;
            uop_in.src1_reg    = pd.rs1;
            uop_in.src2_enable = 1'b1;
            uop_in.src2_reg    = pd.rs2;
            uop_in.dest_enable = 1'b1;
            uop_in.dest_reg    = pd.rd;
            unique case (pd.funct3)
               3'd0: uop_in.sub_op = pd.funct7_alt ? rvu_pkg::UOP_SUB : rvu_pkg::UOP_ADD;
               3'd1: uop_in.sub_op = rvu_pkg::UOP_SLL;
               3'd2: uop_in.sub_op = rvu_pkg::UOP_SLT;
               3'd3: uop_in.sub_op = rvu_pkg::UOP_SLTU;
               3'd4: uop_in.sub_op = rvu_pkg::UOP_XOR;
               3'd5: uop_in.sub_op = pd.funct7_alt ? rvu_pkg::UOP_SRA : rvu_pkg::UOP_SRL;
               3'd6: uop_in.sub_op = rvu_pkg::UOP_OR;
               default: uop_in.sub_op = rvu_pkg::UOP_AND;
            endcase
         end
         rvu_pkg::KIND_FENCE: begin
            uop_in.uop_class = rvu_pkg::CLS_CSR;
            uop_in.sub_op    = (pd.funct3 == 3'd1) ? rvu_pkg::UOP_FENCE_I
                                                    : rvu_pkg::UOP_FENCE;
         end
         rvu_pkg::KIND_SYSTEM: begin
            uop_in.uop_class   = rvu_pkg::CLS_CSR;
            uop_in.src1_enable = 1'b1;
            uop_in.src1_reg    = pd.rs1;
            uop_in.dest_enable = (pd.rd != 5'd0);
            uop_in.dest_reg    = pd.rd;
            unique case (pd.funct3)
               3'd0: begin
                  if (pd.funct12_zero) begin
                     uop_in.sub_op = rvu_pkg::UOP_ECALL;
                  end else if (pd.funct12_one) begin
                     uop_in.sub_op = rvu_pkg::UOP_EBREAK;
                  end else begin
                     uop_in.illegal = 1'b1;
                  end
               end
               3'd1:    uop_in.sub_op = rvu_pkg::UOP_CSRRW;
               3'd2:    uop_in.sub_op = rvu_pkg::UOP_CSRRS;
               3'd3:    uop_in.sub_op = rvu_pkg::UOP_CSRRC;
               3'd5:    uop_in.sub_op = rvu_pkg::UOP_CSRRWI;
               3'd6:    uop_in.sub_op = rvu_pkg::UOP_CSRRSI;
               3'd7:    uop_in.sub_op = rvu_pkg::UOP_CSRRCI;
               default: uop_in.illegal = 1'b1;
            endcase
         end
         default: begin
            uop_in.imm     = '0;
            uop_in.illegal = 1'b1;
         end
      endcase
      // FENCE, OP and SYSTEM carry no immediate; predecode already zeroed it
      uop_in.flags[rvu_pkg::FLG_PTAKEN] = pd.ptaken;
   end

   assign uop_valid = uop_valid_ff;
   assign uop       = uop_ff;

endmodule

[rtl/core/rvu_target.sv]
// Target address adder and result register stage.
module rvu_target (
   input  logic             clock,
   input  logic             reset,
   input  logic             uop_valid,
   input  rvu_pkg::uop_type uop,
   output logic             rsp_valid,
   output rvu_pkg::rsp_type rsp
);

   logic             rsp_valid_ff;
   rvu_pkg::rsp_type rsp_ff;
   rvu_pkg::rsp_type rsp_in;
   logic [63:0]      target_sum;

   assign target_sum = uop.pc + {{32{uop.imm[31]}}, uop.imm};

   always_comb begin
      rsp_in.uop_class     = uop.uop_class;
      rsp_in.sub_op        = uop.sub_op;
      rsp_in.flags         = uop.flags;
      rsp_in.src1_enable   = uop.src1_enable;
      rsp_in.src1_reg      = uop.src1_reg;
      rsp_in.src2_enable   = uop.src2_enable;
      rsp_in.src2_reg      = uop.src2_reg;
      rsp_in.dest_enable   = uop.dest_enable;
      rsp_in.dest_reg      = uop.dest_reg;
      rsp_in.immediate     = $signed(uop.imm);
      rsp_in.target_pc     = uop.target_en ? target_sum : 64'd0;
      rsp_in.illegal_instr = uop.illegal;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= uop_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

[rtl/core/rv32i_to_uop_decoder.sv]
// Top level of the RV32I to micro-op decoder: four-stage decode pipeline.
//
// Accepts one request on every clock edge where start is high; busy is always
// low. Each request comes out as one micro-op on rsp_payload with rsp_strobe high
// for a single cycle: the request passes through the input, predecode,
// micro-op and result registers in that order, and the strobe rises when the
// result register is loaded.
// Results leave in request order. Throughput is one request per cycle. The
// result cannot be held off; a downstream stage must take it in the cycle it
// is shown.
module rv32i_to_uop_decoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rvu_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output rvu_pkg::rsp_type rsp_payload
);

   logic             accept;
   logic             pd_valid;
   rvu_pkg::pd_type  pd;
   logic             uop_valid;
   rvu_pkg::uop_type uop;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   rvu_predecode u_predecode (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_req   (req_payload),
      .pd_valid (pd_valid),
      .pd       (pd)
   );

   rvu_opgen u_opgen (
      .clock     (clock),
      .reset     (reset),
      .pd_valid  (pd_valid),
      .pd        (pd),
      .uop_valid (uop_valid),
      .uop       (uop)
   );

   rvu_target u_target (
      .clock     (clock),
      .reset     (reset),
      .uop_valid (uop_valid),
      .uop       (uop),
      .rsp_valid (rsp_strobe),
      .rsp       (rsp_payload)
   );

`ifndef SYNTHESIS
   a_strobe_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 4))
      else $error("result strobe without a request");

   a_request_gets_strobe: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##4 rsp_strobe)
      else $error("request produced no result");

   a_nop_class_is_illegal: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_payload.uop_class == rvu_pkg::CLS_NOP)
      |-> rsp_payload.illegal_instr && (rsp_payload.sub_op == rvu_pkg::UOP_NOP))
      else $error("nop class on a legal opcode");

   a_target_only_branch: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_payload.target_pc != 64'd0)
      |-> (rsp_payload.uop_class == rvu_pkg::CLS_BR))
      else $error("target given for a non-branch");
`endif

endmodule
